>>> rtl/assert_macros.svh
// Assertion helpers used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NXT_RAW(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA package
// Constants, types and the round mixing function of the TEA pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned TEA_ROUNDS = 32;
  localparam logic [31:0] TEA_DELTA  = 32'h9E37_79B9;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned KEY_IDX_W  = 2;

  typedef enum logic [KEY_IDX_W-1:0] {
    KEY_W0 = 2'd0,
    KEY_W1 = 2'd1,
    KEY_W2 = 2'd2,
    KEY_W3 = 2'd3
  } key_idx_t;

  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  typedef struct packed {
    logic        valid;
    logic        op;
    logic [31:0] v0;
    logic [31:0] v1;
  } tea_stage_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] sum,
                                          input logic [31:0] ka, input logic [31:0] kb);
    tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

>>> rtl/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// TEA block cipher
// Pipelined TEA encryption and decryption of 64-bit blocks under a 128-bit key.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    in_operation, in_block_in
//  out      out_valid / out_stall  out_block_out
//  cfg      cfg_we                 cfg_index, cfg_wdata
//
//  One beat enters per cycle while the input is not stalled; each beat
//  passes through the chain of registered half-round cells in order.
//  Reset clears the key words and all stage valid bits.
//  A stall on a valid output beat freezes the whole cell chain and stalls the input.
// ----------------------------------------------------------------------------
module tea_block_cipher #(
  parameter int unsigned ROUNDS = tea_pkg::TEA_ROUNDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [63:0]                   in_block_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [63:0]                   out_block_out,
  input  logic                          cfg_we,
  input  logic [tea_pkg::KEY_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import tea_pkg::*;

  localparam int unsigned NSTAGE = 2 * ROUNDS;

  key_t       key_r;
  tea_stage_t chain [0:NSTAGE];
  logic       advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (key_idx_t'(cfg_index))
        KEY_W0: key_r[KEY_W0] <= cfg_wdata;
        KEY_W1: key_r[KEY_W1] <= cfg_wdata;
        KEY_W2: key_r[KEY_W2] <= cfg_wdata;
        KEY_W3: key_r[KEY_W3] <= cfg_wdata;
      endcase
    end
  end

  assign advance  = !(chain[NSTAGE].valid && out_stall);
  assign in_stall = !advance;

  always_comb begin
    chain[0].valid = in_valid;
    chain[0].op    = in_operation;
    chain[0].v0    = in_block_in[63:32];
    chain[0].v1    = in_block_in[31:0];
  end

  for (genvar g = 0; g < NSTAGE; g++) begin : g_cell
    localparam logic [63:0] PROD_ENC = 64'(TEA_DELTA) * 64'(g / 2 + 1);
    localparam logic [63:0] PROD_DEC = 64'(TEA_DELTA) * 64'(ROUNDS - g / 2);
    tea_round_cell #(
      .SUM_ENC (PROD_ENC[31:0]),
      .SUM_DEC (PROD_DEC[31:0]),
      .HALF    (1'(g % 2))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .key       (key_r),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  assign out_valid     = chain[NSTAGE].valid;
  assign out_block_out = {chain[NSTAGE].v0, chain[NSTAGE].v1};

endmodule

>>> rtl/tea_round_cell.sv
// ----------------------------------------------------------------------------
// TEA half-round cell
// Updates one half of the block from the other half and holds the result.
// ----------------------------------------------------------------------------
module tea_round_cell #(
  parameter logic [31:0] SUM_ENC = 32'd0,
  parameter logic [31:0] SUM_DEC = 32'd0,
  parameter bit          HALF    = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  tea_pkg::key_t       key,
  input  tea_pkg::tea_stage_t stage_in,
  output tea_pkg::tea_stage_t stage_out
);
  import tea_pkg::*;

  tea_stage_t  stage_r;
  tea_stage_t  stage_nxt;
  logic        src_is_v0;
  logic [31:0] src;
  logic [31:0] tgt;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] sum;
  logic [31:0] mixed;
  logic [31:0] updated;

  always_comb begin
    src_is_v0 = HALF ^ stage_in.op;
    src       = src_is_v0 ? stage_in.v0 : stage_in.v1;
    tgt       = src_is_v0 ? stage_in.v1 : stage_in.v0;
    ka        = src_is_v0 ? key[KEY_W2] : key[KEY_W0];
    kb        = src_is_v0 ? key[KEY_W3] : key[KEY_W1];
    sum       = stage_in.op ? SUM_DEC : SUM_ENC;
    mixed     = tea_mix(src, sum, ka, kb);
    updated   = stage_in.op ? (tgt - mixed) : (tgt + mixed);
    stage_nxt       = stage_in;
    stage_nxt.v0    = src_is_v0 ? stage_in.v0 : updated;
    stage_nxt.v1    = src_is_v0 ? updated : stage_in.v1;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_r.op <= stage_nxt.op;
      stage_r.v0 <= stage_nxt.v0;
      stage_r.v1 <= stage_nxt.v1;
    end
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (advance) begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  assign stage_out = stage_r;

endmodule

>>> rtl/tea_checker.sv
// ----------------------------------------------------------------------------
// TEA port checker
// Checks the handshake and stall behavior seen at the cipher's ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tea_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_block_out
);

  `ASSERT_NXT(a_out_valid_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `ASSERT_NXT(a_out_data_hold, clk, rst_n, out_valid && out_stall, $stable(out_block_out))
  `ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  `ASSERT_IMP(a_no_stall_flow, clk, rst_n, in_valid && !out_stall, !in_stall)
  `ASSERT_NXT_RAW(a_reset_empty, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind tea_block_cipher tea_port_checker u_tea_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_block_out (out_block_out)
);

>>> bench/tea_checker.sv
// ----------------------------------------------------------------------------
// TEA block cipher checker
// Watches the key port and both channels of the cipher, predicts every
// output beat from its own copy of the key and compares it with the block
// that leaves the pipeline.
// ----------------------------------------------------------------------------
module tea_checker #(
  parameter int unsigned ROUNDS = tea_pkg::TEA_ROUNDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_operation,
  input  logic [63:0]                   in_block_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [63:0]                   out_block_out,
  input  logic                          cfg_we,
  input  logic [tea_pkg::KEY_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import tea_pkg::*;

  key_t        key_words;
  logic [63:0] expected_blocks[$];
  logic [63:0] want;

  function automatic logic [31:0] half_round(input logic [31:0] v, input logic [31:0] sum,
                                             input logic [31:0] ka, input logic [31:0] kb);
    return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

  function automatic logic [63:0] tea_transform(input logic decrypt, input logic [63:0] blk,
                                                input key_t key);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    v0 = blk[63:32];
    v1 = blk[31:0];
    if (!decrypt) begin
      sum = '0;
      for (int i = 0; i < ROUNDS; i++) begin
        sum = sum + TEA_DELTA;
        v0  = v0 + half_round(v1, sum, key[KEY_W0], key[KEY_W1]);
        v1  = v1 + half_round(v0, sum, key[KEY_W2], key[KEY_W3]);
      end
    end else begin
      sum = TEA_DELTA * 32'(ROUNDS);
      for (int i = 0; i < ROUNDS; i++) begin
        v1  = v1 - half_round(v0, sum, key[KEY_W2], key[KEY_W3]);
        v0  = v0 - half_round(v1, sum, key[KEY_W0], key[KEY_W1]);
        sum = sum - TEA_DELTA;
      end
    end
    return {v0, v1};
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    key_words  = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      key_words <= '0;
      expected_blocks.delete();
      pending   <= 0;
    end else begin
      // The output beat is matched before this edge's input beat is queued.
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected block_out beat, expected none, actual %h",
                   $time, out_block_out);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_blocks.pop_front();
          if (out_block_out !== want) begin
            $display("%0t: block_out mismatch, expected %h, actual %h",
                     $time, want, out_block_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(tea_transform(in_operation, in_block_in, key_words));
      end
      if (cfg_we) begin
        key_words[cfg_index] <= cfg_wdata;
      end
      pending <= expected_blocks.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// TEA block cipher testbench
// Drives directed and random blocks in both directions under several keys,
// with bursty input and a patterned output stall, and gives the verdict
// from the failure and pending counts of the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import tea_pkg::*;

  localparam int unsigned ROUNDS     = TEA_ROUNDS;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          PHASES     = 8;
  localparam int          PHASE_BEATS = 85;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_operation = OP_ENCRYPT;
  logic [63:0]          in_block_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [63:0]          out_block_out;
  logic                 cfg_we = 1'b0;
  logic [KEY_IDX_W-1:0] cfg_index = KEY_W0;
  logic [31:0]          cfg_wdata = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_mode = 0;

  always #2 clk = ~clk;

  tea_block_cipher #(.ROUNDS(ROUNDS)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_block_in  (in_block_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_block_out(out_block_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  tea_checker #(.ROUNDS(ROUNDS)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_block_in  (in_block_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_block_out(out_block_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Output stall: free flow, heavy random, light random or periodic bursts.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 1) == 0);
      end
      2: begin
        out_stall <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_stall <= ((stall_left % 16) < 5);
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Leaves in_valid high so that the next beat of a burst follows directly.
  task automatic send_block(input logic op, input logic [63:0] blk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_block_in  <= blk;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input key_idx_t idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_key(input key_t key);
    write_reg(KEY_W0, key[KEY_W0]);
    write_reg(KEY_W1, key[KEY_W1]);
    write_reg(KEY_W2, key[KEY_W2]);
    write_reg(KEY_W3, key[KEY_W3]);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_set;
    send_block(OP_ENCRYPT, 64'h0);
    send_block(OP_ENCRYPT, '1);
    send_block(OP_DECRYPT, 64'h0);
    send_block(OP_DECRYPT, '1);
    send_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
    send_block(OP_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_block(OP_ENCRYPT, 64'h5555_5555_5555_5555);
    send_block(OP_ENCRYPT, 64'h8000_0000_0000_0001);
    drain();
  endtask

  initial begin
    key_t        key;
    logic [63:0] blk;
    int          sent;
    int          burst;
    int          gap;
    int          pick;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Key at its reset value first, then the all-ones key.
    directed_set();
    load_key('1);
    directed_set();
    key = {32'h0F1E_2D3C, 32'h4B5A_6978, 32'h8796_A5B4, 32'hC3D2_E1F0};
    load_key(key);
    send_block(OP_ENCRYPT, 64'hFEDC_BA98_7654_3210);
    send_block(OP_DECRYPT, 64'h0000_0001_0000_0000);
    send_block(OP_ENCRYPT, 64'h0000_0000_FFFF_FFFF);
    send_block(OP_DECRYPT, 64'hFFFF_FFFF_0000_0000);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        key = '0;
      end else if (p == 1) begin
        key = '1;
      end else begin
        for (int w = 0; w < KEY_WORDS; w++) begin
          pick = $urandom_range(0, 5);
          key[w] = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        end
      end
      load_key(key);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && sent < PHASE_BEATS; b++) begin
          pick = $urandom_range(0, 15);
          case (pick)
            0: blk = 64'h0;
            1: blk = '1;
            2: blk = 64'h1 << $urandom_range(0, 63);
            3: blk = ~(64'h1 << $urandom_range(0, 63));
            default: blk = {$urandom, $urandom};
          endcase
          send_block(1'($urandom_range(0, 1)), blk);
          sent++;
        end
        if ($urandom_range(0, 30) == 0) begin
          drain();
        end else begin
          gap = $urandom_range(0, 6);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      drain();
    end

    repeat (2 * ROUNDS + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/tea_pkg.sv
rtl/tea_round_cell.sv
rtl/tea_block_cipher.sv
rtl/tea_checker.sv
bench/tea_checker.sv
bench/tb_top.sv
